// ===== rtl/assert_macros.svh =====
// Shared assertion macros. Both expect clk in scope; ASSERT_CLK also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lbps_pkg.sv =====
package lbps_pkg;

	localparam int NUM_PATTERNS_DEF  = 10;
	localparam int MAX_STEPS_DEF     = 8;
	localparam int DURATION_BITS_DEF = 16;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_SET_BG   = 3'd1;
	localparam logic [2:0] OP_ONE_SHOT = 3'd2;
	localparam logic [2:0] OP_SERIAL   = 3'd3;
	localparam logic [2:0] OP_BENCH    = 3'd4;

	// serial ids that play once instead of becoming background
	localparam logic [7:0] SERIAL_ONCE_A = 8'd4;
	localparam logic [7:0] SERIAL_ONCE_B = 8'd5;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] pattern_id;
		logic [7:0] led_arg;
		logic [7:0] buzz_arg;
		logic       bench_on;
	} lbps_in_t;

	typedef struct packed {
		logic       led_level;
		logic       buzzer_level;
		logic [3:0] playing_pattern;
		logic [2:0] step_number;
		logic       one_shot_busy;
		logic       bench_mode;
		logic       bench_led_held;
		logic       bench_buzz_held;
	} lbps_out_t;

	typedef struct packed {
		logic        led;
		logic        buzz;
		logic [15:0] ms;
	} lbps_step_t;

	// raw table length per pattern slot; unused slots are empty
	function automatic logic [3:0] seq_len(input logic [3:0] p);
		logic [3:0] n;
		unique case (p)
			4'd0: n = 4'd2;
			4'd1: n = 4'd2;
			4'd2: n = 4'd2;
			4'd3: n = 4'd4;
			4'd4: n = 4'd4;
			4'd5: n = 4'd6;
			4'd6: n = 4'd4;
			4'd7: n = 4'd2;
			4'd8: n = 4'd5;
			4'd9: n = 4'd6;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic lbps_step_t seq_rom(input logic [3:0] p, input logic [2:0] s);
		lbps_step_t r;
		unique case ({p, s})
			{4'd0, 3'd0}: r = '{1'b1, 1'b0, 16'd60};
			{4'd0, 3'd1}: r = '{1'b0, 1'b0, 16'd2400};
			{4'd1, 3'd0}: r = '{1'b1, 1'b0, 16'd400};
			{4'd1, 3'd1}: r = '{1'b0, 1'b0, 16'd400};
			{4'd2, 3'd0}: r = '{1'b1, 1'b0, 16'd120};
			{4'd2, 3'd1}: r = '{1'b0, 1'b0, 16'd120};
			{4'd3, 3'd0}: r = '{1'b1, 1'b1, 16'd60};
			{4'd3, 3'd1}: r = '{1'b0, 1'b0, 16'd90};
			{4'd3, 3'd2}: r = '{1'b1, 1'b0, 16'd60};
			{4'd3, 3'd3}: r = '{1'b0, 1'b0, 16'd500};
			{4'd4, 3'd0}: r = '{1'b1, 1'b1, 16'd120};
			{4'd4, 3'd1}: r = '{1'b1, 1'b0, 16'd80};
			{4'd4, 3'd2}: r = '{1'b1, 1'b1, 16'd220};
			{4'd4, 3'd3}: r = '{1'b1, 1'b0, 16'd300};
			{4'd5, 3'd0}: r = '{1'b1, 1'b1, 16'd400};
			{4'd5, 3'd1}: r = '{1'b0, 1'b0, 16'd150};
			{4'd5, 3'd2}: r = '{1'b1, 1'b1, 16'd400};
			{4'd5, 3'd3}: r = '{1'b0, 1'b0, 16'd150};
			{4'd5, 3'd4}: r = '{1'b1, 1'b1, 16'd400};
			{4'd5, 3'd5}: r = '{1'b0, 1'b0, 16'd600};
			{4'd6, 3'd0}: r = '{1'b1, 1'b1, 16'd80};
			{4'd6, 3'd1}: r = '{1'b0, 1'b0, 16'd80};
			{4'd6, 3'd2}: r = '{1'b1, 1'b0, 16'd80};
			{4'd6, 3'd3}: r = '{1'b0, 1'b0, 16'd700};
			{4'd7, 3'd0}: r = '{1'b1, 1'b1, 16'd500};
			{4'd7, 3'd1}: r = '{1'b1, 1'b0, 16'd120};
			{4'd8, 3'd0}: r = '{1'b1, 1'b0, 16'd150};
			{4'd8, 3'd1}: r = '{1'b0, 1'b0, 16'd150};
			{4'd8, 3'd2}: r = '{1'b1, 1'b0, 16'd150};
			{4'd8, 3'd3}: r = '{1'b0, 1'b1, 16'd80};
			{4'd8, 3'd4}: r = '{1'b0, 1'b0, 16'd1600};
			{4'd9, 3'd0}: r = '{1'b1, 1'b1, 16'd450};
			{4'd9, 3'd1}: r = '{1'b0, 1'b0, 16'd140};
			{4'd9, 3'd2}: r = '{1'b1, 1'b1, 16'd130};
			{4'd9, 3'd3}: r = '{1'b0, 1'b0, 16'd140};
			{4'd9, 3'd4}: r = '{1'b1, 1'b1, 16'd450};
			{4'd9, 3'd5}: r = '{1'b0, 1'b0, 16'd900};
			default:      r = '{1'b0, 1'b0, 16'd0};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/lbps_player.sv =====
module lbps_player import lbps_pkg::*; #(
	parameter int NUM_PATTERNS  = NUM_PATTERNS_DEF,
	parameter int MAX_STEPS     = MAX_STEPS_DEF,
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  lbps_in_t  item,
	output lbps_out_t result
);

	localparam logic [DURATION_BITS-1:0] CAP = '1;

	// first step of the idle pattern, loaded at reset
	localparam lbps_step_t IDLE_STEP = seq_rom(4'd0, 3'd0);

	logic [3:0]               bg_q, stage_q;
	logic [2:0]               step_q;
	logic [DURATION_BITS-1:0] elapsed_q;
	logic                     oneshot_q, bench_q, bled_q, bbuzz_q, led_q, buzz_q;

	logic [3:0]               bg_n, stage_n;
	logic [2:0]               step_n;
	logic [DURATION_BITS-1:0] elapsed_n;
	logic                     oneshot_n, bench_n, bled_n, bbuzz_n, led_n, buzz_n;

	function automatic logic [3:0] len_of(input logic [3:0] p);
		logic [3:0] n;
		n = seq_len(p);
		return (n > 4'(MAX_STEPS)) ? 4'(MAX_STEPS) : n;
	endfunction

	lbps_step_t               cur_step, app_step;
	logic [3:0]               cur_len, app_len, app_pat;
	logic [2:0]               app_idx;
	logic [DURATION_BITS-1:0] dur, elapsed_inc;
	logic [3:0]               step_inc;
	logic [7:0]               serial_id;
	logic                     pid_ok, serial_ok;
	logic                     do_restart, do_adv;
	logic [3:0]               rst_pat;
	logic [2:0]               adv_idx;

	assign cur_step    = seq_rom(stage_q, step_q);
	assign cur_len     = len_of(stage_q);
	assign dur         = cur_step.ms[DURATION_BITS-1:0];
	assign elapsed_inc = (elapsed_q == CAP) ? elapsed_q : elapsed_q + 1'b1;
	assign step_inc    = {1'b0, step_q} + 4'd1;
	assign serial_id   = (item.buzz_arg > item.led_arg) ? item.buzz_arg : item.led_arg;
	assign pid_ok      = {1'b0, item.pattern_id} < 5'(NUM_PATTERNS);
	assign serial_ok   = {1'b0, serial_id} < 9'(NUM_PATTERNS);

	// command decode: state edits plus restart / step advance requests
	always_comb begin
		bg_n       = bg_q;
		oneshot_n  = oneshot_q;
		bench_n    = bench_q;
		bled_n     = bled_q;
		bbuzz_n    = bbuzz_q;
		elapsed_n  = elapsed_q;
		do_restart = 1'b0;
		rst_pat    = bg_q;
		do_adv     = 1'b0;
		adv_idx    = step_q;
		unique case (item.opcode)
			OP_TICK: begin
				if (!bench_q && ({1'b0, step_q} < cur_len) && (dur != '0)) begin
					if (elapsed_inc < dur) begin
						elapsed_n = elapsed_inc;
					end else if (step_inc >= cur_len) begin
						if (oneshot_q) begin
							oneshot_n  = 1'b0;
							do_restart = 1'b1;
						end else begin
							do_adv  = 1'b1;
							adv_idx = '0;
						end
					end else begin
						do_adv  = 1'b1;
						adv_idx = step_inc[2:0];
					end
				end
			end
			OP_SET_BG: begin
				if (pid_ok) begin
					bg_n = item.pattern_id;
					if (!oneshot_q && item.pattern_id != stage_q) begin
						do_restart = 1'b1;
						rst_pat    = item.pattern_id;
					end
				end
			end
			OP_ONE_SHOT: begin
				if (pid_ok) begin
					oneshot_n  = 1'b1;
					do_restart = 1'b1;
					rst_pat    = item.pattern_id;
				end
			end
			OP_SERIAL: begin
				if (serial_ok) begin
					if (serial_id == SERIAL_ONCE_A || serial_id == SERIAL_ONCE_B) begin
						oneshot_n  = 1'b1;
						do_restart = 1'b1;
						rst_pat    = serial_id[3:0];
					end else begin
						bg_n = serial_id[3:0];
						if (!oneshot_q && serial_id[3:0] != stage_q) begin
							do_restart = 1'b1;
							rst_pat    = serial_id[3:0];
						end
					end
				end
			end
			OP_BENCH: begin
				bench_n = item.bench_on;
				bled_n  = item.led_arg != '0;
				bbuzz_n = item.buzz_arg != '0;
				if (!item.bench_on) begin
					do_restart = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// load levels of the new step
	assign app_pat  = do_restart ? rst_pat : stage_q;
	assign app_idx  = do_restart ? 3'd0 : adv_idx;
	assign app_step = seq_rom(app_pat, app_idx);
	assign app_len  = len_of(app_pat);

	always_comb begin
		stage_n = stage_q;
		step_n  = step_q;
		led_n   = led_q;
		buzz_n  = buzz_q;
		if (do_restart || do_adv) begin
			stage_n = app_pat;
			step_n  = app_idx;
			if ({1'b0, app_idx} < app_len) begin
				led_n  = app_step.led;
				buzz_n = app_step.buzz;
			end else begin
				led_n  = 1'b0;
				buzz_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q      <= '0;
			stage_q   <= '0;
			step_q    <= '0;
			elapsed_q <= '0;
			oneshot_q <= 1'b0;
			bench_q   <= 1'b0;
			bled_q    <= 1'b0;
			bbuzz_q   <= 1'b0;
			led_q     <= IDLE_STEP.led;
			buzz_q    <= IDLE_STEP.buzz;
		end else if (fire) begin
			bg_q      <= bg_n;
			stage_q   <= stage_n;
			step_q    <= step_n;
			elapsed_q <= (do_restart || do_adv) ? '0 : elapsed_n;
			oneshot_q <= oneshot_n;
			bench_q   <= bench_n;
			bled_q    <= bled_n;
			bbuzz_q   <= bbuzz_n;
			led_q     <= led_n;
			buzz_q    <= buzz_n;
		end
	end

	assign result = '{
		led_level:       bench_n ? bled_n : led_n,
		buzzer_level:    bench_n ? bbuzz_n : buzz_n,
		playing_pattern: stage_n,
		step_number:     step_n,
		one_shot_busy:   oneshot_n,
		bench_mode:      bench_n,
		bench_led_held:  bled_n,
		bench_buzz_held: bbuzz_n
	};

endmodule

// ===== rtl/led_buzzer_pattern_sequencer_top.sv =====
// Path: a command beat accepted into the input register passes through one pass of player
//   logic into the result register, which res_stall can hold back.
// Throughput: one command per cycle while the result register is not full and stalled.
// Reset (arst_n low, asynchronous): idle pattern 0 at step 0, LED high, buzzer low,
//   no one-shot, bench mode off, both pipeline stages empty.
module led_buzzer_pattern_sequencer_top import lbps_pkg::*; #(
	parameter int NUM_PATTERNS  = NUM_PATTERNS_DEF,
	parameter int MAX_STEPS     = MAX_STEPS_DEF,
	parameter int DURATION_BITS = DURATION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  lbps_in_t  cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output lbps_out_t res
);

	// Stage 1 holds the command; the player reads it together with its own state
	// and the result lands in the result register. The result register is the
	// only thing that can hold a beat back: while it is full and stalled, stage 1
	// waits, and stage 1 stalls the command side only when it is occupied too.
	logic      valid_s1;
	lbps_in_t  cmd_s1;
	logic      advance;
	logic      fire;
	lbps_out_t result;

	assign advance   = !res_valid || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	// payload needs no reset; it only loads with a fresh beat
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// player state commits exactly when its result moves into the result register
	lbps_player #(
		.NUM_PATTERNS  (NUM_PATTERNS),
		.MAX_STEPS     (MAX_STEPS),
		.DURATION_BITS (DURATION_BITS)
	) u_player (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (cmd_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res <= result;
		end
	end

endmodule

// ===== rtl/lbps_checker.sv =====
`include "assert_macros.svh"

module lbps_checker import lbps_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input logic      res_valid,
	input logic      res_stall,
	input lbps_out_t res
);

	// held result beat keeps its contents
	`ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result beat changed while stalled")

	// back pressure only comes from a full, stalled result register
	`ASSERT_ALWAYS(a_stall_src, cmd_stall |-> res_valid && res_stall, "command stalled without result back pressure")

	// every accepted command is followed by a valid result beat once it has passed stage 1 and the result register
	`ASSERT_CLK(a_latency, cmd_valid && !cmd_stall |-> ##2 res_valid, "no result two cycles after accept")

	// bench mode owns the pins
	`ASSERT_CLK(a_bench_pins, res_valid && res.bench_mode |-> res.led_level == res.bench_led_held && res.buzzer_level == res.bench_buzz_held, "pins differ from bench latches in bench mode")

endmodule

bind led_buzzer_pattern_sequencer_top lbps_checker u_lbps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== tb/sv/tb_led_buzzer_pattern_sequencer_top.sv =====
module tb_led_buzzer_pattern_sequencer_top;
	import lbps_pkg::*;

	// Pattern tables, one entry per pattern id; bit s of the LED and buzzer words is step s.
	localparam int NPAT    = NUM_PATTERNS_DEF;
	localparam int MAXS    = MAX_STEPS_DEF;
	localparam int DUR_CAP = (1 << DURATION_BITS_DEF) - 1;

	localparam int       PAT_STEPS [10] = '{2, 2, 2, 4, 4, 6, 4, 2, 5, 6};
	localparam bit [7:0] PAT_LED   [10] = '{8'h01, 8'h01, 8'h01, 8'h05, 8'h0f,
		8'h15, 8'h05, 8'h03, 8'h05, 8'h15};
	localparam bit [7:0] PAT_BUZZ  [10] = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h05,
		8'h15, 8'h01, 8'h01, 8'h08, 8'h15};
	localparam int       PAT_MS [10][8] = '{
		'{60, 2400, 0, 0, 0, 0, 0, 0},
		'{400, 400, 0, 0, 0, 0, 0, 0},
		'{120, 120, 0, 0, 0, 0, 0, 0},
		'{60, 90, 60, 500, 0, 0, 0, 0},
		'{120, 80, 220, 300, 0, 0, 0, 0},
		'{400, 150, 400, 150, 400, 600, 0, 0},
		'{80, 80, 80, 700, 0, 0, 0, 0},
		'{500, 120, 0, 0, 0, 0, 0, 0},
		'{150, 150, 150, 80, 1600, 0, 0, 0},
		'{450, 140, 130, 140, 450, 900, 0, 0}
	};

	// opcodes the block must treat as no-ops
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 8;	// margin after the last result, covering stalls

	// Tracks the player state per accepted command and holds the status beats still owed.
	class sequencer_score;
		int        bg_pat, stage_pat, step;
		bit        one_shot, bench, bench_led, bench_buzz, led_pin, buzz_pin;
		int        elapsed;
		lbps_out_t status_due[$];
		int        errors, checked, commands, fallbacks, wraps, benches;

		function new();
			bg_pat = 0;
			one_shot = 0;
			bench = 0;
			bench_led = 0;
			bench_buzz = 0;
			restart(0);
		endfunction

		function int steps_of(int p);
			int n;
			n = (p < NPAT && p < 10) ? PAT_STEPS[p] : 0;
			return (n > MAXS) ? MAXS : n;
		endfunction

		function void load_step();
			if (step < steps_of(stage_pat)) begin
				led_pin = PAT_LED[stage_pat][step];
				buzz_pin = PAT_BUZZ[stage_pat][step];
			end else begin
				led_pin = 0;
				buzz_pin = 0;
			end
			elapsed = 0;
		endfunction

		function void restart(int p);
			stage_pat = p & 15;
			step = 0;
			load_step();
		endfunction

		function void set_bg(int p);
			if (p >= NPAT)
				return;
			bg_pat = p;
			if (!one_shot && p != stage_pat)
				restart(p);
		endfunction

		function void play_once(int p);
			if (p >= NPAT)
				return;
			one_shot = 1;
			restart(p);
		endfunction

		function void tick();
			int len;
			int dur;
			if (bench)
				return;
			len = steps_of(stage_pat);
			if (step >= len)
				return;
			dur = PAT_MS[stage_pat][step] & DUR_CAP;
			if (dur == 0)
				return;
			if (elapsed < DUR_CAP)
				elapsed++;
			if (elapsed < dur)
				return;
			step++;
			if (step >= len) begin
				if (one_shot) begin
					one_shot = 0;
					fallbacks++;
					restart(bg_pat);
					return;
				end
				step = 0;
				wraps++;
			end
			load_step();
		endfunction

		function void take_command(lbps_in_t c);
			int        id;
			lbps_out_t r;
			commands++;
			case (c.opcode)
				OP_TICK: tick();
				OP_SET_BG: set_bg(c.pattern_id);
				OP_ONE_SHOT: play_once(c.pattern_id);
				OP_SERIAL: begin
					id = (c.buzz_arg > c.led_arg) ? c.buzz_arg : c.led_arg;
					if (id < NPAT) begin
						if (id == SERIAL_ONCE_A || id == SERIAL_ONCE_B)
							play_once(id);
						else
							set_bg(id);
					end
				end
				OP_BENCH: begin
					if (c.bench_on && !bench)
						benches++;
					bench = c.bench_on;
					bench_led = (c.led_arg != 0);
					bench_buzz = (c.buzz_arg != 0);
					if (!c.bench_on)
						restart(bg_pat);
				end
				default: ;
			endcase
			r.led_level = bench ? bench_led : led_pin;
			r.buzzer_level = bench ? bench_buzz : buzz_pin;
			r.playing_pattern = stage_pat[3:0];
			r.step_number = step[2:0];
			r.one_shot_busy = one_shot;
			r.bench_mode = bench;
			r.bench_led_held = bench_led;
			r.bench_buzz_held = bench_buzz;
			status_due.push_back(r);
		endfunction

		function void field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_status(lbps_out_t got);
			lbps_out_t want;
			if (status_due.size() == 0) begin
				$display("%0t: unexpected status beat %h", $time, got);
				errors++;
				return;
			end
			want = status_due.pop_front();
			checked++;
			field("led_level", want.led_level, got.led_level);
			field("buzzer_level", want.buzzer_level, got.buzzer_level);
			field("playing_pattern", want.playing_pattern, got.playing_pattern);
			field("step_number", want.step_number, got.step_number);
			field("one_shot_busy", want.one_shot_busy, got.one_shot_busy);
			field("bench_mode", want.bench_mode, got.bench_mode);
			field("bench_led_held", want.bench_led_held, got.bench_led_held);
			field("bench_buzz_held", want.bench_buzz_held, got.bench_buzz_held);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	lbps_in_t  cmd;
	logic      res_valid;
	logic      res_stall;
	lbps_out_t res;

	sequencer_score score = new();
	bit             steady;		// when set, neither side idles
	int             res_hold;	// stall cycles still owed before the next status beat
	int             cycles;

	led_buzzer_pattern_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Status side: sample at the rising edge, stall changes at the falling edge.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			score.check_status(res);
			res_hold = steady ? 0 : $urandom_range(0, 3);
		end
	end

	always @(negedge clk) begin
		if (res_hold > 0) begin
			res_stall <= 1'b1;
			res_hold--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	function automatic lbps_in_t mk(logic [2:0] op, logic [3:0] pid, logic [7:0] la,
		logic [7:0] ba, logic on);
		lbps_in_t c;
		c.opcode = op;
		c.pattern_id = pid;
		c.led_arg = la;
		c.buzz_arg = ba;
		c.bench_on = on;
		return c;
	endfunction

	// Entered and left at a falling edge. Valid stays high between back-to-back beats;
	// whoever stops sending next must lower it.
	task automatic send_cmd(lbps_in_t c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (cmd_stall);
		score.take_command(c);
		@(negedge clk);
	endtask

	// Hold off the command side until every owed status beat has come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (score.status_due.size() != 0)
			@(negedge clk);
	endtask

	// Bias toward patterns with short steps so steps and one-shots actually complete.
	function automatic logic [3:0] pick_pattern();
		logic [3:0] p;
		case ($urandom_range(0, 5))
			0: p = 4'd2;
			1: p = 4'd3;
			2: p = 4'd6;
			default: p = 4'($urandom_range(0, 15));
		endcase
		return p;
	endfunction

	function automatic lbps_in_t noise();
		return mk(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endfunction

	initial begin
		lbps_in_t c;
		int       issued;
		int       kind;
		int       n;
		int       r;

		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		res_hold = 0;
		steady = 1'b0;
		cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle pattern after reset, ignored ids, one-shot holding the stage,
		// serial max-id rule and the play-once ids, bench freeze and exit, no-op opcodes.
		send_cmd(mk(OP_TICK, 4'd15, 8'd255, 8'd255, 1'b1));
		send_cmd(mk(OP_TICK, 4'd0, 8'd0, 8'd0, 1'b0));
		send_cmd(mk(OP_SET_BG, 4'd3, 8'd0, 8'd0, 1'b0));
		send_cmd(mk(OP_SET_BG, 4'd3, 8'd255, 8'd0, 1'b0));	// same as stage: no restart
		send_cmd(mk(OP_SET_BG, 4'd15, 8'd0, 8'd0, 1'b0));	// out of range
		send_cmd(mk(OP_SET_BG, 4'd10, 8'd0, 8'd0, 1'b0));
		send_cmd(mk(OP_ONE_SHOT, 4'd2, 8'd0, 8'd0, 1'b0));
		send_cmd(mk(OP_ONE_SHOT, 4'd12, 8'd0, 8'd0, 1'b0));
		send_cmd(mk(OP_SET_BG, 4'd9, 8'd0, 8'd0, 1'b0));	// background only, one-shot holds
		send_cmd(mk(OP_SERIAL, 4'd0, 8'd4, 8'd0, 1'b0));
		send_cmd(mk(OP_SERIAL, 4'd0, 8'd0, 8'd5, 1'b0));
		send_cmd(mk(OP_SERIAL, 4'd0, 8'd255, 8'd0, 1'b0));	// larger id out of range
		send_cmd(mk(OP_SERIAL, 4'd0, 8'd7, 8'd9, 1'b0));
		send_cmd(mk(OP_SERIAL, 4'd0, 8'd0, 8'd0, 1'b0));
		drain();
		send_cmd(mk(OP_BENCH, 4'd0, 8'd255, 8'd1, 1'b1));
		send_cmd(mk(OP_TICK, 4'd0, 8'd0, 8'd0, 1'b0));	// frozen in bench
		send_cmd(mk(OP_ONE_SHOT, 4'd6, 8'd0, 8'd0, 1'b0));
		send_cmd(mk(OP_BENCH, 4'd0, 8'd0, 8'd0, 1'b1));
		send_cmd(mk(OP_BENCH, 4'd0, 8'd1, 8'd0, 1'b0));	// leave: background restarts
		send_cmd(mk(OP_RSVD_5, 4'd15, 8'd255, 8'd255, 1'b1));
		send_cmd(mk(OP_RSVD_6, 4'd15, 8'd255, 8'd255, 1'b1));
		send_cmd(mk(OP_RSVD_7, 4'd15, 8'd255, 8'd255, 1'b1));
		drain();

		// Random scenes: one command, then a run of ticks, often long enough to move through steps.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				steady = ~steady;
			kind = $urandom_range(0, 99);
			c = noise();
			if (score.bench && kind < 75) begin
				c.opcode = OP_BENCH;
				c.bench_on = 1'b0;
			end else if (kind < 20) begin
				c.opcode = OP_SET_BG;
				c.pattern_id = pick_pattern();
			end else if (kind < 40) begin
				c.opcode = OP_ONE_SHOT;
				c.pattern_id = pick_pattern();
			end else if (kind < 65) begin
				c.opcode = OP_SERIAL;
				if ($urandom_range(0, 1)) begin
					c.led_arg = 8'($urandom_range(0, 11));
					c.buzz_arg = 8'($urandom_range(0, 11));
				end
			end else if (kind < 80) begin
				c.opcode = OP_BENCH;
				if ($urandom_range(0, 1))
					c.led_arg = 8'd0;
				if ($urandom_range(0, 1))
					c.buzz_arg = 8'd0;
			end else if (kind < 85) begin
				c.opcode = 3'($urandom_range(int'(OP_RSVD_5), int'(OP_RSVD_7)));
			end
			send_cmd(c);
			issued++;

			r = $urandom_range(0, 99);
			if (score.bench)
				n = $urandom_range(0, 3);
			else if (r < 50)
				n = $urandom_range(0, 20);
			else if (r < 85)
				n = $urandom_range(50, 130);
			else
				n = $urandom_range(130, 260);
			repeat (n) begin
				send_cmd(noise());
				issued++;
			end
			if ($urandom_range(0, 15) == 0)
				drain();
		end

		cmd_valid <= 1'b0;
		@(negedge clk);
		while (score.status_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d command beats, checked %0d status beats.", score.commands,
			score.checked);
		$display("Saw %0d one-shot returns to background, %0d pattern loops, %0d bench entries.",
			score.fallbacks, score.wraps, score.benches);
		if (score.errors == 0 && score.status_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lbps_pkg.sv
rtl/lbps_player.sv
rtl/led_buzzer_pattern_sequencer_top.sv
rtl/lbps_checker.sv
tb/sv/tb_led_buzzer_pattern_sequencer_top.sv
